@@ rtl/core/kmsm_pkg.sv @@
`timescale 1ns / 1ps

package kmsm_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_SLOTS_DEF  = 8;
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 32;
  localparam int CAP_W    = 5;
  localparam int ID_W     = 3;
  localparam int PDATA_W  = 32;
  localparam int STATUS_W = 2;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET    = 2'd0,
    ACT_PUSH   = 2'd1,
    ACT_POP    = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_NOFREE    = 2'd3
  } status_t;

  // Classified request as it travels from front to back
  typedef struct packed {
    action_t             action;
    logic [KEY_W-1:0]    key;
    logic [CAP_W-1:0]    cap;     // already clamped to 1..DEPTH
    logic [ID_W-1:0]     id;
    logic                id_ok;   // id addresses an existing slot
    logic [PDATA_W-1:0]  data;
  } req_t;

endpackage

@@ rtl/core/kmsm_ram.sv @@
`timescale 1ns / 1ps

module kmsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/kmsm_front.sv @@
`timescale 1ns / 1ps

module kmsm_front
  import kmsm_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int DEPTH     = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [KEY_W-1:0]    key,
  input  logic [CAP_W-1:0]    capacity,
  input  logic [ID_W-1:0]     stack_id,
  input  logic [PDATA_W-1:0]  push_data,
  output logic                q_valid,
  output req_t                q_head,
  input  logic                q_pop
);

  req_t               req_in;
  logic [CAP_W-1:0]   cap_clamped;
  req_t               q_mem [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] q_cnt;
  logic               push_q;
  logic               pop_q;

  // Clamp requested capacity to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (32'(capacity) > DEPTH) begin
      cap_clamped = CAP_W'(DEPTH);
    end else begin
      cap_clamped = capacity;
    end
  end

  // Classify the incoming request
  always_comb begin
    req_in.action = action_t'(action);
    req_in.key    = key;
    req_in.cap    = cap_clamped;
    req_in.id     = stack_id;
    req_in.id_ok  = (32'(stack_id) < NUM_SLOTS);
    req_in.data   = push_data;
  end

  assign cmd_ready = (q_cnt < Q_CNT_W'(QUEUE_DEPTH));
  assign push_q    = cmd_valid && cmd_ready;
  assign q_valid   = (q_cnt != '0);
  assign pop_q     = q_pop && q_valid;
  assign q_head    = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_q) begin
      q_mem[wr_ptr] <= req_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push_q) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop_q) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push_q && !pop_q) begin
        q_cnt <= q_cnt + Q_CNT_W'(1);
      end else if (pop_q && !push_q) begin
        q_cnt <= q_cnt - Q_CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/kmsm_back.sv @@
`timescale 1ns / 1ps

module kmsm_back
  import kmsm_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  req_t                q_head,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     slot_out,
  output logic [PDATA_W-1:0]  pop_data
);

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRIES = NUM_SLOTS * DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_EXEC   = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t                  state;
  req_t                    cur;
  logic [KEY_W-1:0]        slot_key      [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    slot_used;
  logic [CNT_W-1:0]        slot_capacity [NUM_SLOTS];
  logic [CNT_W-1:0]        slot_count    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    hit_vec;
  logic [NUM_SLOTS-1:0]    free_vec;
  status_t                 res_status;
  logic [SLOT_W-1:0]       res_slot;
  logic                    pop_ok;

  logic [SLOT_W-1:0]       sid;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        capv;
  logic [CNT_W-1:0]        cnt_dec;
  logic [SLOT_W-1:0]       hit_slot;
  logic [SLOT_W-1:0]       free_slot;
  logic                    push_ok;
  logic                    pop_go;
  logic                    ram_wr_en;
  logic                    ram_rd_en;
  logic [ADDR_W-1:0]       ram_wr_addr;
  logic [ADDR_W-1:0]       ram_rd_addr;
  logic [DATA_WIDTH-1:0]   ram_wr_data;
  logic [DATA_WIDTH-1:0]   ram_rd_data;
  logic                    out_free;

  // Lowest set bit of a slot vector
  function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_SLOTS-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  // Addressed slot state
  assign sid       = SLOT_W'(cur.id);
  assign cnt       = slot_count[sid];
  assign capv      = slot_capacity[sid];
  assign cnt_dec   = cnt - CNT_W'(1);
  assign hit_slot  = first_set(hit_vec);
  assign free_slot = first_set(free_vec);
  assign push_ok   = cur.id_ok && (cnt < capv);
  assign pop_go    = cur.id_ok && (cnt != '0);
  assign out_free  = !res_valid || res_ready;

  // Element store access, issued in the execute step
  assign ram_wr_en   = (state == S_EXEC) && (cur.action == ACT_PUSH) && push_ok;
  assign ram_rd_en   = (state == S_EXEC) && (cur.action == ACT_POP) && pop_go;
  assign ram_wr_addr = ADDR_W'(32'(sid) * DEPTH + 32'(cnt));
  assign ram_rd_addr = ADDR_W'(32'(sid) * DEPTH + 32'(cnt_dec));
  assign ram_wr_data = DATA_WIDTH'(cur.data);

  kmsm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign q_pop = (state == S_IDLE) && q_valid;

  // Sequencer, slot table and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot_used <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_key[i]      <= '0;
        slot_capacity[i] <= '0;
        slot_count[i]    <= '0;
      end
    end else begin
      // result valid: set on hand-over, cleared once taken
      if ((state == S_RESP) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_head;
            state <= (q_head.action == ACT_GET) ? S_SEARCH : S_EXEC;
          end
        end
        S_SEARCH: begin
          // match all slots in use against the key
          for (int i = 0; i < NUM_SLOTS; i++) begin
            hit_vec[i] <= slot_used[i] && (slot_key[i] == cur.key);
          end
          free_vec <= ~slot_used;
          state    <= S_EXEC;
        end
        S_EXEC: begin
          res_status <= STAT_OK;
          res_slot   <= '0;
          pop_ok     <= 1'b0;
          case (cur.action)
            ACT_GET: begin
              if (hit_vec != '0) begin
                res_slot <= hit_slot;
              end else if (free_vec != '0) begin
                res_slot                 <= free_slot;
                slot_used[free_slot]     <= 1'b1;
                slot_key[free_slot]      <= cur.key;
                slot_capacity[free_slot] <= CNT_W'(cur.cap);
              end else begin
                res_status <= STAT_NOFREE;
              end
            end
            ACT_PUSH: begin
              if (push_ok) begin
                slot_count[sid] <= cnt + CNT_W'(1);
              end else begin
                res_status <= STAT_OVERFLOW;
              end
            end
            ACT_POP: begin
              if (pop_go) begin
                slot_count[sid] <= cnt_dec;
                pop_ok          <= 1'b1;
              end else begin
                res_status <= STAT_UNDERFLOW;
              end
            end
            default: begin
              if (cur.id_ok) begin
                slot_used[sid]  <= 1'b0;
                slot_key[sid]   <= '0;
                slot_count[sid] <= '0;
              end
            end
          endcase
          state <= S_RESP;
        end
        S_RESP: begin
          // hand the result over once the output register is free
          if (out_free) begin
            status    <= res_status;
            slot_out  <= ID_W'(res_slot);
            pop_data  <= pop_ok ? PDATA_W'(ram_rd_data) : '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/keyed_multi_stack_manager.sv @@
`timescale 1ns / 1ps

// Keyed multi-stack manager: NUM_SLOTS stacks share one element RAM of
// NUM_SLOTS*DEPTH entries, each slot owning DEPTH entries. A get request
// (action 0) returns the slot in use that holds the key, or claims the
// lowest free slot with the capacity clamped to 1..DEPTH; push, pop and
// remove work on the slot given by stack_id. Requests are taken into a
// two-entry queue and carried out one at a time by the back-end sequencer:
// a get goes from the queue head to the result register through dequeue,
// key match over all slots, update and respond steps; push, pop and remove
// skip the key match; a pop reads the element RAM through its registered
// read port. The result register lets new requests enter while a result
// waits. The element RAM needs no clearing after reset: pop only reads
// entries pushed since the slot's count was last cleared by reset or remove.
module keyed_multi_stack_manager
  import kmsm_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [KEY_W-1:0]    key,
  input  logic [CAP_W-1:0]    capacity,
  input  logic [ID_W-1:0]     stack_id,
  input  logic [PDATA_W-1:0]  push_data,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     slot_out,
  output logic [PDATA_W-1:0]  pop_data
);

  logic q_valid;
  logic q_pop;
  req_t q_head;

  // Accept and classify requests
  kmsm_front #(
    .NUM_SLOTS (NUM_SLOTS),
    .DEPTH     (DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .action    (action),
    .key       (key),
    .capacity  (capacity),
    .stack_id  (stack_id),
    .push_data (push_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  // Execute requests against the slot table and element store
  kmsm_back #(
    .NUM_SLOTS  (NUM_SLOTS),
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .status    (status),
    .slot_out  (slot_out),
    .pop_data  (pop_data)
  );

endmodule
